// ===== sv/wavetable_oscillator_core_assert.svh =====
`ifndef WAVETABLE_OSCILLATOR_CORE_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define WTO_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("wto check failed: implication");

// next-cycle implication
`define WTO_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("wto check failed: next cycle");

`endif

// ===== sv/wto_pkg.sv =====
package wto_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 12;
    localparam int PHASE_W     = 32;
    localparam int FRAC_W      = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PHASE_W-1:0] FREE_PHASE_LIMIT = 32'd4290672329;

    localparam logic [1:0] CMD_SAMPLE      = 2'd0;
    localparam logic [1:0] CMD_LOAD_A      = 2'd1;
    localparam logic [1:0] CMD_LOAD_B      = 2'd2;
    localparam logic [1:0] CMD_PHASE_RESET = 2'd3;

    localparam logic [1:0] REG_PHASE_INC  = 2'd0;
    localparam logic [1:0] REG_TABLE_SIZE = 2'd1;
    localparam logic [1:0] REG_WAVE_MIX   = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_inc;
        logic [SIZE_W-1:0]  table_size;
        logic [FRAC_W-1:0]  wave_mix;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                    cmd;
        logic [PHASE_W-1:0]            rd_phase;
        logic [ADDR_W-1:0]             addr;
        logic signed [SAMPLE_BITS-1:0] value;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/wavetable_oscillator_core.sv =====
// Sample request: queue, then registered index/multiply, table read, interpolate, crossfade;
// rsp_stall can hold it in crossfade; back end takes a new sample only after loading the last.
// Table loads retire one per cycle while the back end is idle; phase resets complete at acceptance.
// Front accepts while the 2-entry queue has room. Config writes are always accepted and registered.
// rst_n async active low: phase, control, config cleared (table_size = 2048); tables undefined until written.
module wavetable_oscillator_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [1:0]          command,
    input  logic signed [31:0]  fm_offset,
    input  logic [10:0]         table_addr,
    input  logic signed [15:0]  table_value,
    input  logic [31:0]         start_phase,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic signed [15:0]  sample,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import wto_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    q_entry_t  push_entry;
    q_entry_t  head_entry;
    q_status_t q_status;
    logic      q_push;
    logic      q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PHASE_INC:  cfg_next.phase_inc  = cfg_data;
                REG_TABLE_SIZE: cfg_next.table_size = cfg_data[SIZE_W-1:0];
                REG_WAVE_MIX:   cfg_next.wave_mix   = cfg_data[FRAC_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_inc  <= '0;
            cfg_reg.table_size <= SIZE_W'(TABLE_DEPTH);
            cfg_reg.wave_mix   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wto_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .fm_offset   (fm_offset),
        .table_addr  (table_addr),
        .table_value (table_value),
        .start_phase (start_phase),
        .phase_inc   (cfg_reg.phase_inc),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    wto_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (head_entry),
        .status    (q_status)
    );

    wto_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_entry   (head_entry),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sample    (sample)
    );

endmodule

// ===== sv/wto_front.sv =====
module wto_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            command,
    input  logic signed [31:0]    fm_offset,
    input  logic [10:0]           table_addr,
    input  logic signed [15:0]    table_value,
    input  logic [31:0]           start_phase,
    input  logic [31:0]           phase_inc,
    input  wto_pkg::q_status_t    q_status,
    output logic                  q_push,
    output wto_pkg::q_entry_t     q_entry
);
    import wto_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               accept;

    assign req_stall = q_status.full;
    assign accept    = req_valid && !req_stall;
    assign q_push    = accept && (command != CMD_PHASE_RESET);

    assign q_entry.cmd      = command;
    assign q_entry.rd_phase = phase_reg + PHASE_W'(unsigned'(fm_offset));
    assign q_entry.addr     = table_addr[ADDR_W-1:0];
    assign q_entry.value    = table_value[SAMPLE_BITS-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (command)
                CMD_SAMPLE:
                begin
                    phase_next = phase_reg + phase_inc;
                end
                CMD_PHASE_RESET:
                begin
                    if (start_phase < FREE_PHASE_LIMIT)
                    begin
                        phase_next = start_phase;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/wto_queue.sv =====
module wto_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wto_pkg::q_entry_t  push_data,
    input  logic               pop,
    output wto_pkg::q_entry_t  pop_data,
    output wto_pkg::q_status_t status
);
    import wto_pkg::*;

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/wto_back.sv =====
module wto_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wto_pkg::cfg_t         cfg,
    input  wto_pkg::q_entry_t     q_entry,
    input  wto_pkg::q_status_t    q_status,
    output logic                  q_pop,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic signed [15:0]    sample
);
    import wto_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LERP = 2'd2;
    localparam logic [1:0] ST_MIX  = 2'd3;

    function automatic logic signed [SAMPLE_BITS-1:0] lerp(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic signed [SAMPLE_BITS-1:0] y,
        input logic [FRAC_W-1:0]             w
    );
        logic signed [SAMPLE_BITS:0]          d;
        logic signed [SAMPLE_BITS+FRAC_W+1:0] p;
        logic signed [SAMPLE_BITS+1:0]        s;
        d = (SAMPLE_BITS+1)'(y) - (SAMPLE_BITS+1)'(x);
        p = d * $signed({1'b0, w});
        s = (SAMPLE_BITS+2)'(x) + $signed(p[SAMPLE_BITS+FRAC_W+1:FRAC_W]);
        return s[SAMPLE_BITS-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] mem_a [TABLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_b [TABLE_DEPTH];

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [ADDR_W-1:0]             i1_reg;
    logic [ADDR_W-1:0]             i2_reg;
    logic [FRAC_W-1:0]             frac_reg;
    logic signed [SAMPLE_BITS-1:0] a0_reg;
    logic signed [SAMPLE_BITS-1:0] a1_reg;
    logic signed [SAMPLE_BITS-1:0] b0_reg;
    logic signed [SAMPLE_BITS-1:0] b1_reg;
    logic signed [SAMPLE_BITS-1:0] wa_reg;
    logic signed [SAMPLE_BITS-1:0] wb_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic [SIZE_W-1:0]             size_eff;
    logic [PHASE_W+SIZE_W-1:0]     prod;
    logic [ADDR_W:0]               i2_full;
    logic [ADDR_W-1:0]             i1_new;
    logic [ADDR_W-1:0]             i2_new;
    logic                          wr_a;
    logic                          wr_b;
    logic                          load_out;

    always_comb
    begin
        priority if (cfg.table_size == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (cfg.table_size > SIZE_W'(TABLE_DEPTH))
        begin
            size_eff = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size_eff = cfg.table_size;
        end
    end

    assign prod    = (PHASE_W+SIZE_W)'(q_entry.rd_phase) * (PHASE_W+SIZE_W)'(size_eff);
    assign i1_new  = prod[PHASE_W +: ADDR_W];
    assign i2_full = {1'b0, i1_new} + 1'b1;
    assign i2_new  = (SIZE_W'(i2_full) >= size_eff) ? '0 : i2_full[ADDR_W-1:0];

    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign wr_a     = q_pop && (q_entry.cmd == CMD_LOAD_A);
    assign wr_b     = q_pop && (q_entry.cmd == CMD_LOAD_B);
    assign load_out = (state_reg == ST_MIX) && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid = rsp_valid_reg;
    assign sample    = sample_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && (q_entry.cmd == CMD_SAMPLE))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LERP;
            end
            ST_LERP:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            i1_reg   <= i1_new;
            i2_reg   <= i2_new;
            frac_reg <= prod[PHASE_W-1 -: FRAC_W];
        end
        if (state_reg == ST_LERP)
        begin
            wa_reg <= lerp(a0_reg, a1_reg, frac_reg);
            wb_reg <= lerp(b0_reg, b1_reg, frac_reg);
        end
        if (load_out)
        begin
            sample_reg <= lerp(wa_reg, wb_reg, cfg.wave_mix);
        end
    end

    // table storage, write one / read two per wave
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[q_entry.addr] <= q_entry.value;
        end
        if (wr_b)
        begin
            mem_b[q_entry.addr] <= q_entry.value;
        end
        if (state_reg == ST_READ)
        begin
            a0_reg <= mem_a[i1_reg];
            a1_reg <= mem_a[i2_reg];
            b0_reg <= mem_b[i1_reg];
            b1_reg <= mem_b[i2_reg];
        end
    end

endmodule

// ===== sv/wto_checker.sv =====
`include "wavetable_oscillator_core_assert.svh"

module wto_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [15:0] sample,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // a held result keeps its value
    `WTO_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(sample))

    // queue regains room when no requests arrive and results are taken
    `WTO_ASSERT_IMPLIES(a_queue_drains, clk, rst_n,
        $past(!req_valid && !rsp_stall, 1) && $past(!req_valid && !rsp_stall, 2) &&
        $past(!req_valid && !rsp_stall, 3) && $past(!req_valid && !rsp_stall, 4) &&
        $past(!req_valid && !rsp_stall, 5), !req_stall)

    // config writes are never refused
    `WTO_ASSERT_IMPLIES(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind wavetable_oscillator_core wto_checker u_checker (.*);
